// ===== rtl/unsigned_divider_128_defines.svh =====
// assertion macros for the 128-bit unsigned divider
// no dependencies; included by the files that carry assertions
`ifndef UNSIGNED_DIVIDER_128_DEFINES_SVH
`define UNSIGNED_DIVIDER_128_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define UD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("udiv check failed");

// next-cycle implication, disabled while in reset
`define UD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("udiv check failed");

`endif

// ===== rtl/udiv_pkg.sv =====
// shared widths, types and control struct of the 128-bit unsigned divider
// no dependencies; used by udiv_datapath, udiv_ctrl and unsigned_divider_128
package udiv_pkg;

	localparam int HALF_W = 64;
	localparam int WORD_W = 2 * HALF_W;
	localparam int CNT_W  = $clog2(WORD_W);

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [WORD_W-1:0] word_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} udiv_ctrl_t;

endpackage

// ===== rtl/udiv_datapath.sv =====
// shift-subtract datapath: remainder, dividend/quotient and divisor registers
// around one shared 129-bit subtractor; depends on udiv_pkg
module udiv_datapath (
	input  logic                clk,
	input  udiv_pkg::udiv_ctrl_t ctrl,
	input  udiv_pkg::word_t     dividend,
	input  udiv_pkg::word_t     divisor,
	input  logic                div_zero,
	output udiv_pkg::word_t     quotient,
	output logic                dbz
);
	import udiv_pkg::*;

	word_t              rem_q;
	word_t              quo_q;
	word_t              den_q;
	logic               dbz_q;
	logic [WORD_W:0]    cand;
	logic [WORD_W+1:0]  diff;
	logic               qbit;

	// partial remainder with next dividend bit, trial subtract
	always_comb begin
		cand = {rem_q, quo_q[WORD_W-1]};
		diff = {1'b0, cand} - {2'b00, den_q};
		qbit = ~diff[WORD_W+1];
	end

	// load operands, then one quotient bit per step
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
			dbz_q <= div_zero;
		end else if (ctrl.step) begin
			rem_q <= qbit ? diff[WORD_W-1:0] : cand[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], qbit};
		end
	end

	// zero divisor forces a zero quotient
	assign quotient = dbz_q ? '0 : quo_q;
	assign dbz      = dbz_q;

endmodule

// ===== rtl/udiv_ctrl.sv =====
// sequencer of the divider: idle, run 128 steps (none for a zero divisor), hand the result over
// depends on udiv_pkg
module udiv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 div_zero,
	input  logic                 slot_free,
	output udiv_pkg::udiv_ctrl_t ctrl,
	output logic                 busy
);
	import udiv_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_q;

	// next state and commands
	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctrl.load = 1'b1;
					state_d   = div_zero ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					ctrl.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				cnt_q <= '0;
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/unsigned_divider_128.sv =====
// 128-bit unsigned divider, one quotient bit per cycle by restoring division.
// An item is loaded, then takes 128 shift-subtract steps through the single
// 129-bit subtractor, then its quotient moves into the output register once
// that register is free; a zero divisor skips the steps and returns quotient
// zero with divide_by_zero set. req_stall stays high from acceptance until the
// result has moved to the output register, so a new item may be taken while
// the previous result still waits on rsp_stall.
// Depends on udiv_pkg, udiv_ctrl, udiv_datapath and the defines header.
`include "unsigned_divider_128_defines.svh"

module unsigned_divider_128 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  udiv_pkg::half_t     dividend_high,
	input  udiv_pkg::half_t     dividend_low,
	input  udiv_pkg::half_t     divisor_high,
	input  udiv_pkg::half_t     divisor_low,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output udiv_pkg::half_t     quotient_high,
	output udiv_pkg::half_t     quotient_low,
	output logic                divide_by_zero
);
	import udiv_pkg::*;

	udiv_ctrl_t ctrl;
	logic       busy;
	logic       div_zero;
	logic       slot_free;
	word_t      quotient;
	logic       dbz;
	logic       rsp_valid_q;
	word_t      quo_out_q;
	logic       dbz_out_q;

	assign div_zero  = (divisor_high == '0) && (divisor_low == '0);
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// sequencer
	udiv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.div_zero  (div_zero),
		.slot_free (slot_free),
		.ctrl      (ctrl),
		.busy      (busy)
	);

	// shift-subtract datapath
	udiv_datapath u_datapath (
		.clk      (clk),
		.ctrl     (ctrl),
		.dividend ({dividend_high, dividend_low}),
		.divisor  ({divisor_high, divisor_low}),
		.div_zero (div_zero),
		.quotient (quotient),
		.dbz      (dbz)
	);

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output item payload
	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			quo_out_q <= quotient;
			dbz_out_q <= dbz;
		end
	end

	assign req_stall      = busy;
	assign rsp_valid      = rsp_valid_q;
	assign quotient_high  = quo_out_q[WORD_W-1:HALF_W];
	assign quotient_low   = quo_out_q[HALF_W-1:0];
	assign divide_by_zero = dbz_out_q;

	// checks
	`UD_ASSERT_NEXT(a_accept_busy, clk, arst_n, req_valid && !req_stall, req_stall)
	`UD_ASSERT_NEXT(a_finish_valid, clk, arst_n, ctrl.finish, rsp_valid && !req_stall)
	`UD_ASSERT_IMP(a_dbz_zero, clk, arst_n, rsp_valid && divide_by_zero, (quotient_high == '0) && (quotient_low == '0))

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for unsigned_divider_128: directed and random 128-bit divisions
// depends on udiv_pkg and the unsigned_divider_128 rtl; restoring-division predictor built in
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import udiv_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 20000;
	localparam int unsigned DRAIN_CYCLES = 140;
	localparam int unsigned RANDOM_ITEMS = 600;
	localparam int unsigned HOLD_AT      = 120;
	localparam int unsigned HOLD_CYCLES  = 1500;

	// expected outcome of one division
	typedef struct {
		half_t hi;
		half_t lo;
		logic  dbz;
	} quotient_t;

	// predicts quotients in order of acceptance and checks the results against them
	class quotient_scoreboard;
		quotient_t   pending_quotients[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function int unsigned lead_zeros(word_t v);
			int unsigned n;
			n = 0;
			for (int i = WORD_W - 1; i >= 0 && !v[i]; i--)
				n++;
			return n;
		endfunction

		// restoring shift-subtract division after aligning the divisor
		function quotient_t divide_restoring(word_t num, word_t den);
			quotient_t   res;
			word_t       quo;
			word_t       rem;
			word_t       d;
			int unsigned sh;
			quo = '0;
			rem = num;
			res.dbz = 1'b0;
			if (den == '0) begin
				res.dbz = 1'b1;
			end else if (num < den) begin
				quo = '0;
			end else if (num == den) begin
				quo = word_t'(1);
			end else begin
				sh = lead_zeros(den) - lead_zeros(num);
				d = den << sh;
				for (int i = 0; i <= int'(sh); i++) begin
					quo = quo << 1;
					if (rem >= d) begin
						rem = rem - d;
						quo[0] = 1'b1;
					end
					d = d >> 1;
				end
			end
			res.hi = quo[WORD_W-1:HALF_W];
			res.lo = quo[HALF_W-1:0];
			return res;
		endfunction

		function void note_division(word_t dividend, word_t divisor);
			pending_quotients.insert(pending_quotients.size(),
				divide_restoring(dividend, divisor));
		endfunction

		function void check_quotient(half_t hi, half_t lo, logic dbz);
			quotient_t exp_q;
			if (pending_quotients.size() == 0) begin
				$error("quotient item with no division pending");
				errors++;
				return;
			end
			exp_q = pending_quotients.pop_front();
			if (hi !== exp_q.hi) begin
				$error("quotient_high: expected %h, got %h", exp_q.hi, hi);
				errors++;
			end
			if (lo !== exp_q.lo) begin
				$error("quotient_low: expected %h, got %h", exp_q.lo, lo);
				errors++;
			end
			if (dbz !== exp_q.dbz) begin
				$error("divide_by_zero: expected %b, got %b", exp_q.dbz, dbz);
				errors++;
			end
		endfunction

		function int unsigned pending_count();
			return pending_quotients.size();
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	half_t dividend_high;
	half_t dividend_low;
	half_t divisor_high;
	half_t divisor_low;
	logic  rsp_valid;
	logic  rsp_stall;
	half_t quotient_high;
	half_t quotient_low;
	logic  divide_by_zero;

	quotient_scoreboard sb = new();
	int unsigned        idle_cycles  = 0;
	int unsigned        results_seen = 0;
	bit                 send_burst   = 1'b0;
	bit                 recv_burst   = 1'b0;

	unsigned_divider_128 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.dividend_high (dividend_high),
		.dividend_low  (dividend_low),
		.divisor_high  (divisor_high),
		.divisor_low   (divisor_low),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.quotient_high (quotient_high),
		.quotient_low  (quotient_low),
		.divide_by_zero(divide_by_zero)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sample both handshakes, feed the scoreboard and watch for a hang
	always @(posedge clk) begin
		bit took_req;
		bit took_rsp;
		took_req = arst_n && req_valid && !req_stall;
		took_rsp = arst_n && rsp_valid && !rsp_stall;
		if (took_req)
			sb.note_division({dividend_high, dividend_low}, {divisor_high, divisor_low});
		if (took_rsp) begin
			sb.check_quotient(quotient_high, quotient_low, divide_by_zero);
			results_seen <= results_seen + 1;
		end
		if (took_req || took_rsp)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// gap length: mostly none or short, a few long, none at all in burst stretches
	function automatic int unsigned pick_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 200);
	endfunction

	// random 128-bit value with a random number of leading zeros
	function automatic word_t rand_word();
		word_t v;
		v = {$urandom, $urandom, $urandom, $urandom};
		return v >> $urandom_range(0, WORD_W - 1);
	endfunction

	// offer one division and hold it until the block takes it
	task automatic offer_division(input word_t dividend, input word_t divisor);
		int unsigned gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		dividend_high <= dividend[WORD_W-1:HALF_W];
		dividend_low  <= dividend[HALF_W-1:0];
		divisor_high  <= divisor[WORD_W-1:HALF_W];
		divisor_low   <= divisor[HALF_W-1:0];
		req_valid     <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		bit          held;
		int unsigned r;
		held = 1'b0;
		rsp_stall = 1'b0;
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				recv_burst = !recv_burst;
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!recv_burst && r < 40) begin
				rsp_stall <= 1'b1;
				repeat (pick_gap(1'b0) + 1) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat (recv_burst ? 200 : $urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	// reset, directed cases, random divisions, drain
	initial begin
		word_t       a;
		word_t       b;
		int unsigned k;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		dividend_high = '0;
		dividend_low  = '0;
		divisor_high  = '0;
		divisor_low   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero divisor, whatever the dividend
		offer_division('0, '0);
		offer_division('1, '0);
		offer_division(128'd1, '0);
		// divisor above dividend
		offer_division('0, 128'd1);
		offer_division(128'd1, '1);
		offer_division((128'd1 << 127) - 1, 128'd1 << 127);
		// equal operands
		offer_division('1, '1);
		offer_division(128'd1, 128'd1);
		offer_division({64'd1, 64'd0}, {64'd1, 64'd0});
		// full-length quotients and alignment extremes
		offer_division('1, 128'd1);
		offer_division('1, 128'd2);
		offer_division('1, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE});
		offer_division({64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 128'd3);
		offer_division(128'd1 << 127, 128'd1);
		offer_division(128'd1 << 127, (128'd1 << 127) - 1);
		offer_division(128'd1000, 128'd7);
		offer_division('1, {64'd1, 64'd0});
		offer_division({64'd0, 64'h8000_0000_0000_0000}, 128'h1_0000_0000);
		offer_division('1, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});

		// random divisions over a spread of magnitudes
		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				send_burst = !send_burst;
			k = $urandom_range(0, 99);
			a = rand_word();
			if (k < 5) begin
				b = '0;
			end else if (k < 10) begin
				b = a;
			end else if (k < 20) begin
				a = {$urandom, $urandom, $urandom, $urandom};
				b = {$urandom, $urandom, $urandom, $urandom};
			end else if (k < 30) begin
				a = {$urandom, $urandom, $urandom, $urandom};
				b = rand_word() >> $urandom_range(64, 120);
			end else begin
				b = rand_word();
			end
			offer_division(a, b);
		end
		req_valid <= 1'b0;

		// wait for every quotient, then a little longer for strays
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/udiv_pkg.sv
rtl/udiv_datapath.sv
rtl/udiv_ctrl.sv
rtl/unsigned_divider_128.sv
tb/tb_top.sv
